// ===== design/dedup_chunk_metadata_table_top_macros.svh =====
// Assertion macros shared by the checker of the dedup chunk metadata table.
// Depends on nothing; included by the checker file.
`ifndef DEDUP_CHUNK_METADATA_TABLE_TOP_MACROS_SVH
`define DEDUP_CHUNK_METADATA_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dcmt_pkg.sv =====
// Package of the dedup chunk metadata table: sizes, payload types, command and
// status structs between controller and datapath, and the fingerprint mask.
// Depends on nothing.
package dcmt_pkg;

  // Table geometry.
  localparam int unsigned ENTRIES    = 1024;
  localparam int unsigned SLOTS      = 4;
  localparam int unsigned ENT_AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SLOT_DEPTH = ENTRIES * SLOTS;
  localparam int unsigned SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(SLOTS + 1);
  localparam int unsigned PTR_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths.
  localparam int unsigned OPC_W      = 2;
  localparam int unsigned LOC_W      = 10;
  localparam int unsigned LBA_W      = 64;
  localparam int unsigned FP_HI_W    = 64;
  localparam int unsigned FP_MID_W   = 64;
  localparam int unsigned FP_LO_W    = 32;
  localparam int unsigned FP_W       = FP_HI_W + FP_MID_W + FP_LO_W;
  localparam int unsigned FP_BYTES   = FP_W / 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned VERDICT_W  = 2;
  localparam int unsigned FPLEN_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FP_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK = 2'd1;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_BOTH      = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ADDR_ONLY = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_FP_ONLY   = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_NONE      = 2'd3;

  typedef enum logic [OPC_W-1:0] {
    OP_VERIFY = 2'd0,
    OP_DUP    = 2'd1,
    OP_NEW    = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [LOC_W-1:0]    location;
    logic [LBA_W-1:0]    lba;
    logic                has_fp;
    logic [FP_HI_W-1:0]  fp_word_hi;
    logic [FP_MID_W-1:0] fp_word_mid;
    logic [FP_LO_W-1:0]  fp_word_lo;
    logic [LEN_W-1:0]    compressed_len;
  } req_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [LEN_W-1:0]     stored_len;
    logic                 flush_valid;
    logic [LBA_W-1:0]     flush_lba;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_req_t;

  // One metadata entry as held in the entry memory.
  typedef struct packed {
    logic [FP_W-1:0]  fp;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt;
    logic [PTR_W-1:0] ptr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Memory write kinds ordered by the controller.
  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_CLEAR  = 3'd1,
    WR_APPEND = 3'd2,
    WR_CREATE = 3'd3,
    WR_EVICT  = 3'd4
  } wr_kind_e;

  // Which address slot is read.
  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_NEXT  = 2'd1,
    RD_EVICT = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic     capture;
    logic     ent_latch;
    logic     slot_rd;
    rd_sel_e  rd_sel;
    wr_kind_e wr_kind;
    logic     set_hit;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    loc_ok;
    logic    cnt_zero;
    logic    full;
    logic    hit;
    logic    last;
    logic    clr_last;
    logic    out_free;
  } dp_status_t;

  // Byte mask over the 160-bit fingerprint: the leading n bytes are set,
  // where n saturates at the fingerprint length.
  function automatic logic [FP_W-1:0] fp_mask(input logic [FPLEN_W-1:0] n);
    logic [FPLEN_W-1:0] n_eff;
    logic [FP_W-1:0]    mask;
    n_eff = (n > FPLEN_W'(FP_BYTES)) ? FPLEN_W'(FP_BYTES) : n;
    mask  = '0;
    for (int i = 0; i < FP_BYTES; i++) begin
      if (FPLEN_W'(i) < n_eff) begin
        mask[FP_W-1-8*i -: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage

// ===== design/dcmt_req_if.sv =====
// Request channel of the dedup chunk metadata table: valid, ready, payload.
// Depends on dcmt_pkg.
interface dcmt_req_if import dcmt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dcmt_rsp_if.sv =====
// Result channel of the dedup chunk metadata table: valid, ready, payload.
// Depends on dcmt_pkg.
interface dcmt_rsp_if import dcmt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dcmt_cfg_if.sv =====
// Configuration write channel: valid, ready, register index and write data.
// Depends on dcmt_pkg.
interface dcmt_cfg_if import dcmt_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/dcmt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dcmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/dcmt_ctrl.sv =====
// Controller of the dedup chunk metadata table: sequences the clearing pass,
// the entry lookup, the address scan or eviction and the result handoff. Depends on dcmt_pkg.
module dcmt_ctrl import dcmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_ENTRY = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_EVICT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_kind = WR_CLEAR;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        cmd_o.ent_latch = 1'b1;
        state_d         = ST_DONE;
        if (status_i.loc_ok) begin
          case (status_i.op)
            OP_VERIFY: begin
              if (!status_i.cnt_zero) begin
                cmd_o.slot_rd = 1'b1;
                cmd_o.rd_sel  = RD_FIRST;
                state_d       = ST_SCAN;
              end
            end
            OP_DUP: begin
              if (status_i.full) begin
                cmd_o.slot_rd = 1'b1;
                cmd_o.rd_sel  = RD_EVICT;
                state_d       = ST_EVICT;
              end else begin
                cmd_o.wr_kind = WR_APPEND;
              end
            end
            OP_NEW: begin
              cmd_o.wr_kind = WR_CREATE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_DONE;
        end else if (status_i.last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.slot_rd = 1'b1;
          cmd_o.rd_sel  = RD_NEXT;
        end
      end
      ST_EVICT: begin
        cmd_o.wr_kind = WR_EVICT;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/dcmt_datapath.sv =====
// Datapath of the dedup chunk metadata table: entry and address memories,
// request and entry registers, compare logic, configuration and result register.
// Depends on dcmt_pkg and dcmt_ram.
module dcmt_datapath import dcmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  req_t       req_data_i,
  input  logic       cfg_valid_i,
  input  cfg_req_t   cfg_data_i,
  output logic       cfg_ready_o,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output rsp_t       rsp_data_o
);

  req_t               req_q;
  entry_t             ent_q;
  logic [PTR_W-1:0]   scan_q, scan_d;
  logic               hit_q, fp_ok_q;
  logic               flush_valid_q;
  logic [LBA_W-1:0]   flush_lba_q;
  logic [ENT_AW-1:0]  clr_q;
  logic [FPLEN_W-1:0] fp_len_q;
  logic               wb_mode_q;
  logic               rsp_valid_q;
  rsp_t               rsp_q, rsp_d;

  logic [ENTRY_W-1:0] ent_rdata;
  entry_t             ent_rd, ent_view, ent_wdata;
  logic               ent_we;
  logic [ENT_AW-1:0]  ent_idx, ent_waddr;
  logic [LBA_W-1:0]   slot_rdata;
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_base, slot_raddr, slot_waddr;
  logic [PTR_W-1:0]   slot_rd_idx, slot_wr_idx, ptr_next;
  logic [CNT_W-1:0]   ptr_inc;
  logic [FP_W-1:0]    mask, req_fp;
  logic               loc_ok;

  assign ent_rd   = entry_t'(ent_rdata);
  assign ent_view = cmd_i.ent_latch ? ent_rd : ent_q;
  assign ent_idx  = ENT_AW'(req_q.location);
  assign loc_ok   = (32'(req_q.location) < ENTRIES);
  assign mask     = fp_mask(fp_len_q);
  assign req_fp   = {req_q.fp_word_hi, req_q.fp_word_mid, req_q.fp_word_lo};
  assign slot_base = SLOT_AW'(ent_idx) * SLOT_AW'(SLOTS);

  // Round-robin eviction pointer advance with wrap.
  assign ptr_inc  = CNT_W'(ent_q.ptr) + CNT_W'(1);
  assign ptr_next = (ptr_inc >= CNT_W'(SLOTS)) ? '0 : PTR_W'(ptr_inc);

  // Address slot read selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST: slot_rd_idx = '0;
      RD_NEXT:  slot_rd_idx = scan_q + PTR_W'(1);
      RD_EVICT: slot_rd_idx = ent_view.ptr;
      default:  slot_rd_idx = '0;
    endcase
  end
  assign slot_raddr = slot_base + SLOT_AW'(slot_rd_idx);
  assign scan_d     = cmd_i.slot_rd ? slot_rd_idx : scan_q;

  // Memory write data for each write kind.
  always_comb begin
    ent_we      = 1'b0;
    ent_waddr   = ent_idx;
    ent_wdata   = ent_view;
    slot_we     = 1'b0;
    slot_wr_idx = '0;
    case (cmd_i.wr_kind)
      WR_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = '0;
      end
      WR_APPEND: begin
        ent_we        = 1'b1;
        ent_wdata.cnt = ent_view.cnt + CNT_W'(1);
        slot_we       = 1'b1;
        slot_wr_idx   = PTR_W'(ent_view.cnt);
      end
      WR_CREATE: begin
        ent_we        = 1'b1;
        ent_wdata.fp  = req_fp & mask;
        ent_wdata.len = req_q.compressed_len;
        ent_wdata.cnt = CNT_W'(1);
        ent_wdata.ptr = '0;
        slot_we       = 1'b1;
      end
      WR_EVICT: begin
        ent_we        = 1'b1;
        ent_wdata     = ent_q;
        ent_wdata.ptr = ptr_next;
        slot_we       = 1'b1;
        slot_wr_idx   = ent_q.ptr;
      end
      default: begin
        ent_we = 1'b0;
      end
    endcase
  end
  assign slot_waddr = slot_base + SLOT_AW'(slot_wr_idx);

  // Entry store: fingerprint, length, fill count and eviction pointer.
  dcmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (ENT_AW'(req_data_i.location)),
    .rdata_o (ent_rdata)
  );

  // Address slot store, SLOTS rows per entry.
  dcmt_ram #(
    .WIDTH (LBA_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (req_q.lba),
    .re_i    (cmd_i.slot_rd),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Status toward the controller.
  always_comb begin
    status_o.op       = opcode_e'(req_q.opcode);
    status_o.loc_ok   = loc_ok;
    status_o.cnt_zero = (ent_view.cnt == '0);
    status_o.full     = (ent_view.cnt >= CNT_W'(SLOTS));
    status_o.hit      = (slot_rdata == req_q.lba);
    status_o.last     = ((CNT_W'(scan_q) + CNT_W'(1)) >= ent_q.cnt);
    status_o.clr_last = (clr_q == ENT_AW'(ENTRIES - 1));
    status_o.out_free = !rsp_valid_q || rsp_ready_i;
  end

  // Result assembly.
  always_comb begin
    rsp_d = '0;
    if (opcode_e'(req_q.opcode) == OP_VERIFY) begin
      if (!loc_ok) begin
        rsp_d.verdict = VERDICT_NONE;
      end else begin
        if (hit_q && fp_ok_q) begin
          rsp_d.verdict = VERDICT_BOTH;
        end else if (hit_q) begin
          rsp_d.verdict = VERDICT_ADDR_ONLY;
        end else if (fp_ok_q) begin
          rsp_d.verdict = VERDICT_FP_ONLY;
        end else begin
          rsp_d.verdict = VERDICT_NONE;
        end
        rsp_d.stored_len = ent_q.len;
      end
    end else if (opcode_e'(req_q.opcode) == OP_DUP && loc_ok) begin
      rsp_d.flush_valid = flush_valid_q;
      rsp_d.flush_lba   = flush_lba_q;
    end
  end

  // Control registers: clear counter, flags, configuration, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q         <= '0;
      hit_q         <= 1'b0;
      fp_ok_q       <= 1'b0;
      flush_valid_q <= 1'b0;
      fp_len_q      <= FPLEN_W'(FP_BYTES);
      wb_mode_q     <= 1'b1;
      rsp_valid_q   <= 1'b0;
      scan_q        <= '0;
    end else begin
      scan_q <= scan_d;
      if (cmd_i.wr_kind == WR_CLEAR) begin
        clr_q <= clr_q + ENT_AW'(1);
      end
      if (cmd_i.capture) begin
        hit_q         <= 1'b0;
        flush_valid_q <= 1'b0;
      end
      if (cmd_i.set_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.ent_latch) begin
        fp_ok_q <= req_q.has_fp && (((ent_rd.fp ^ req_fp) & mask) == '0);
      end
      if (cmd_i.wr_kind == WR_EVICT) begin
        flush_valid_q <= wb_mode_q;
      end
      if (cfg_valid_i) begin
        case (cfg_data_i.index)
          CFG_FP_LENGTH:  fp_len_q  <= cfg_data_i.value;
          CFG_WRITE_BACK: wb_mode_q <= cfg_data_i.value[0];
          default: begin
            wb_mode_q <= wb_mode_q;
          end
        endcase
      end
      if (cmd_i.load_out) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q       <= req_data_i;
      flush_lba_q <= '0;
    end
    if (cmd_i.ent_latch) begin
      ent_q <= ent_rd;
    end
    if (cmd_i.wr_kind == WR_EVICT) begin
      flush_lba_q <= wb_mode_q ? slot_rdata : '0;
    end
    if (cmd_i.load_out) begin
      rsp_q <= rsp_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_q;

endmodule

// ===== design/dedup_chunk_metadata_table_top.sv =====
// Dedup chunk metadata table: 1024 entries of fingerprint, four addresses,
// fill count, eviction pointer and compressed length.
//
// Channels: req_i takes one request (verify, update duplicate, create entry);
// rsp_o returns exactly one result per request, in order; cfg_i writes the
// fingerprint length (index 0) and write-back mode (index 1) and is always ready.
// Requests are handled one at a time. After a request is taken its entry is read;
// a verify then scans the address slots one after another (up to 4), and an update
// of a full entry reads and replaces the slot at the eviction pointer; then the
// result register is loaded, and the next request is taken only after that. The
// sequential slot scan over the single read port of the address memory sets the pace.
// After reset a clearing pass zeroes the entry memory, one entry a cycle, over all
// 1024 entries; no request is taken meanwhile, configuration writes are.
// A stalled receiver holds the result register; the block then finishes the
// current request and waits before taking another.
// Depends on dcmt_pkg, the channel interfaces, dcmt_ctrl and dcmt_datapath.
module dedup_chunk_metadata_table_top import dcmt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  dcmt_req_if.sink         req_i,
  dcmt_rsp_if.source       rsp_o,
  dcmt_cfg_if.sink         cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing.
  dcmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage and compare logic.
  dcmt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_data_i  (req_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_o.data)
  );

endmodule

// ===== design/dcmt_checker.sv =====
// Port-level checker for the dedup chunk metadata table and its bind.
// Depends on dcmt_pkg and the assertion macro header.
`include "dedup_chunk_metadata_table_top_macros.svh"

module dcmt_checker import dcmt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  // A stalled result stays offered and unchanged.
  `DCMT_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i), "result changed while stalled")

  // One request at a time: ready drops right after a request is taken.
  `DCMT_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while another was in progress")

  // No flush address without a flush.
  `DCMT_ASSERT_SAME(a_flush_lba_zero, clk_i, rst_ni, rsp_valid_i && !rsp_data_i.flush_valid, rsp_data_i.flush_lba == '0, "flush address set without flush")

  // A flush comes only from an update, whose verify fields are zero.
  `DCMT_ASSERT_SAME(a_flush_from_update, clk_i, rst_ni, rsp_valid_i && rsp_data_i.flush_valid, rsp_data_i.verdict == VERDICT_BOTH && rsp_data_i.stored_len == '0, "flush on a verify result")

endmodule

bind dedup_chunk_metadata_table_top dcmt_checker u_dcmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
